// ===== src/ppd_pkg.sv =====
// Shared types and constants of the pointer packet decoder.
// No dependencies; every other source file uses this package.
package ppd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned BTN_W   = 5;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned HELD_N  = 3;

	localparam logic [MODE_W-1:0] MODE_STD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WHEEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FIVE  = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX_STD = 2'd2;
	localparam logic [IDX_W-1:0] LAST_IDX_EXT = 2'd3;

	typedef struct packed {
		logic              done;
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		logic [BYTE_W-1:0] b3;
	} pkt_t;

	function automatic logic is_ext(input logic [MODE_W-1:0] mode);
		return (mode == MODE_WHEEL) || (mode == MODE_FIVE);
	endfunction

endpackage

// ===== src/ppd_if.sv =====
// Valid/ready channel interfaces of the pointer packet decoder:
// configuration writes, input bytes and position results. Uses ppd_pkg.
interface ppd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ppd_pkg::MODE_W-1:0]    mouse_mode;

	modport source (output valid, output mouse_mode, input ready);
	modport sink   (input valid, input mouse_mode, output ready);
endinterface

interface ppd_byte_if;
	logic                          valid;
	logic                          ready;
	logic [ppd_pkg::BYTE_W-1:0]    data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface ppd_pos_if;
	logic                             valid;
	logic                             ready;
	logic signed [ppd_pkg::POS_W-1:0] pos_x;
	logic signed [ppd_pkg::POS_W-1:0] pos_y;
	logic signed [ppd_pkg::POS_W-1:0] pos_z;
	logic [ppd_pkg::BTN_W-1:0]        buttons;

	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output buttons, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input pos_z,
		input buttons, output ready);
endinterface

// ===== src/ppd_asm.sv =====
// Packet assembler: byte counter, held bytes and packet completion.
// Depends on ppd_pkg.
module ppd_asm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ppd_pkg::BYTE_W-1:0] data_byte,
	input  logic                       adv,
	input  logic                       cfg_wr,
	input  logic [ppd_pkg::MODE_W-1:0] mode,
	output ppd_pkg::pkt_t              pkt,
	output logic [ppd_pkg::IDX_W-1:0]  idx
);
	import ppd_pkg::*;

	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] held_q [HELD_N];
	logic [IDX_W-1:0]  last_idx;

	assign last_idx = is_ext(mode) ? LAST_IDX_EXT : LAST_IDX_STD;
	assign idx      = idx_q;

	always_comb begin
		pkt.done = (idx_q >= last_idx);
		pkt.b0   = (idx_q == 2'd0) ? data_byte : held_q[0];
		pkt.b1   = (idx_q == 2'd1) ? data_byte : held_q[1];
		pkt.b2   = (idx_q == 2'd2) ? data_byte : held_q[2];
		pkt.b3   = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cfg_wr) begin
			idx_q <= '0;
		end else if (adv) begin
			idx_q <= pkt.done ? '0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && idx_q != LAST_IDX_EXT) begin
			held_q[idx_q] <= data_byte;
		end
	end

endmodule

// ===== src/ppd_acc.sv =====
// Position and button accumulators, updated once per completed packet.
// Depends on ppd_pkg.
module ppd_acc (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ppd_pkg::pkt_t                     pkt,
	input  logic                              fire,
	input  logic [ppd_pkg::MODE_W-1:0]        mode,
	output logic signed [ppd_pkg::POS_W-1:0]  pos_x,
	output logic signed [ppd_pkg::POS_W-1:0]  pos_y,
	output logic signed [ppd_pkg::POS_W-1:0]  pos_z,
	output logic [ppd_pkg::BTN_W-1:0]         buttons
);
	import ppd_pkg::*;

	logic [POS_W-1:0] acc_x_q;
	logic [POS_W-1:0] acc_y_q;
	logic [POS_W-1:0] acc_z_q;
	logic [BTN_W-1:0] btn_q;
	logic [POS_W-1:0] dx;
	logic [POS_W-1:0] dy;
	logic [POS_W-1:0] dz;
	logic [BTN_W-1:0] btn_d;

	always_comb begin
		dx = {{(POS_W-BYTE_W){pkt.b0[4]}}, pkt.b1};
		dy = {{(POS_W-BYTE_W){pkt.b0[5]}}, pkt.b2};
		btn_d = {btn_q[4:3], pkt.b0[2:0]};
		dz = '0;
		if (mode == MODE_WHEEL) begin
			dz = {{(POS_W-BYTE_W){pkt.b3[7]}}, pkt.b3};
		end else if (mode == MODE_FIVE) begin
			dz = {{(POS_W-4){pkt.b3[3]}}, pkt.b3[3:0]};
			btn_d[4:3] = pkt.b3[5:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
			btn_q   <= '0;
		end else if (fire) begin
			acc_x_q <= acc_x_q + dx;
			acc_y_q <= acc_y_q - dy;
			acc_z_q <= acc_z_q + dz;
			btn_q   <= btn_d;
		end
	end

	assign pos_x   = signed'(acc_x_q);
	assign pos_y   = signed'(acc_y_q);
	assign pos_z   = signed'(acc_z_q);
	assign buttons = btn_q;

endmodule

// ===== src/pointer_packet_decoder.sv =====
// Top level of the pointer packet decoder: input register, assembler,
// accumulators and result valid. Depends on ppd_pkg, ppd_if, ppd_asm, ppd_acc.
//
// Takes one mouse byte per clock cycle, except while a packet's last byte waits
// on a stalled result, and for each completed packet (three bytes in standard
// mode, four in wheel and five-button modes) presents the running X, Y and Z
// positions and the five buttons as one result item. A byte passes an input
// register and then updates the accumulators, which double as the result
// register. The result waits in place while the sink stalls; bytes that do not
// complete a packet keep flowing meanwhile. Writing mouse_mode restarts packet
// gathering and drops any partial packet; mode 3 acts as standard mode.
module pointer_packet_decoder (
	input  logic       clk,
	input  logic       arst_n,
	ppd_cfg_if.sink    cfg,
	ppd_byte_if.sink   din,
	ppd_pos_if.source  dout
);
	import ppd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	logic [MODE_W-1:0] mode_q;
	logic              adv;
	logic              fire;
	logic [IDX_W-1:0]  idx;
	pkt_t              pkt;

	assign adv       = valid_s1 && (!pkt.done || !out_valid_q || dout.ready);
	assign fire      = adv && pkt.done;
	assign din.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;
	assign dout.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			byte_s1 <= din.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STD;
		end else if (cfg.valid) begin
			mode_q <= cfg.mouse_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	ppd_asm u_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (byte_s1),
		.adv       (adv),
		.cfg_wr    (cfg.valid),
		.mode      (mode_q),
		.pkt       (pkt),
		.idx       (idx)
	);

	ppd_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt),
		.fire    (fire),
		.mode    (mode_q),
		.pos_x   (dout.pos_x),
		.pos_y   (dout.pos_y),
		.pos_z   (dout.pos_z),
		.buttons (dout.buttons)
	);

	a_std_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!is_ext(mode_q) |-> idx != LAST_IDX_EXT)
		else $error("byte counter past last byte of a standard packet");

	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("completed packet did not raise result valid");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(dout.pos_x) && $stable(dout.pos_y) && $stable(dout.pos_z))
		else $error("position changed without a completed packet");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !dout.ready |-> !fire)
		else $error("result overwritten while stalled");

endmodule

// ===== tb/testbench.sv =====
// Testbench of pointer_packet_decoder: mouse bytes in, positions and buttons out.
// Predicts each result from its own copy of the packet state and checks every field.
// Depends on ppd_pkg, ppd_if and pointer_packet_decoder.
module testbench;
	import ppd_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 150;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [BTN_W-1:0]        btn;
	} position_t;

	class pointer_tracker;
		logic [MODE_W-1:0] mode = MODE_STD;
		logic [IDX_W-1:0]  idx = '0;
		logic [BYTE_W-1:0] held[HELD_N];
		logic [POS_W-1:0]  acc_x = '0;
		logic [POS_W-1:0]  acc_y = '0;
		logic [POS_W-1:0]  acc_z = '0;
		logic [BTN_W-1:0]  btn = '0;
		position_t         positions_due[$];
		int unsigned       errors = 0;

		function void set_mode(input logic [MODE_W-1:0] m);
			mode = m;
			idx = '0;
		endfunction

		function void note_byte(input logic [BYTE_W-1:0] b);
			logic [IDX_W-1:0]  last;
			logic [BYTE_W-1:0] p0;
			position_t         due;
			last = (mode == MODE_WHEEL || mode == MODE_FIVE) ? LAST_IDX_EXT : LAST_IDX_STD;
			if (idx < last) begin
				held[idx] = b;
				idx = idx + 1'b1;
				return;
			end
			if (idx < 2'd3)
				held[idx] = b;
			idx = '0;
			p0 = held[0];
			btn[2:0] = p0[2:0];
			acc_x = acc_x + {{24{p0[4]}}, held[1]};
			acc_y = acc_y - {{24{p0[5]}}, held[2]};
			if (mode == MODE_WHEEL) begin
				acc_z = acc_z + {{24{b[7]}}, b};
			end else if (mode == MODE_FIVE) begin
				acc_z = acc_z + {{28{b[3]}}, b[3:0]};
				btn[3] = b[4];
				btn[4] = b[5];
			end
			due.x = acc_x;
			due.y = acc_y;
			due.z = acc_z;
			due.btn = btn;
			positions_due.push_back(due);
		endfunction

		function void check_position(input logic signed [POS_W-1:0] x,
			input logic signed [POS_W-1:0] y, input logic signed [POS_W-1:0] z,
			input logic [BTN_W-1:0] b);
			position_t due;
			if (positions_due.size() == 0) begin
				$error("result item with no expectation: x %0d y %0d z %0d buttons %0h",
					x, y, z, b);
				errors++;
				return;
			end
			due = positions_due.pop_front();
			if (x !== due.x) begin
				$error("pos_x expected %0d got %0d", due.x, x);
				errors++;
			end
			if (y !== due.y) begin
				$error("pos_y expected %0d got %0d", due.y, y);
				errors++;
			end
			if (z !== due.z) begin
				$error("pos_z expected %0d got %0d", due.z, z);
				errors++;
			end
			if (b !== due.btn) begin
				$error("buttons expected %0h got %0h", due.btn, b);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return positions_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_req = 0;
	pointer_tracker tracker;

	ppd_cfg_if  cfg_ch ();
	ppd_byte_if byte_ch ();
	ppd_pos_if  pos_ch ();

	pointer_packet_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.din    (byte_ch),
		.dout   (pos_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial tracker = new;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pos_ch.valid && pos_ch.ready)
				tracker.check_position(pos_ch.pos_x, pos_ch.pos_y, pos_ch.pos_z,
					pos_ch.buttons);
			if (cfg_ch.valid && cfg_ch.ready)
				tracker.set_mode(cfg_ch.mouse_mode);
			if (byte_ch.valid && byte_ch.ready)
				tracker.note_byte(byte_ch.data_byte);
		end
	end

	initial begin
		int unsigned hold_left;
		hold_left = 0;
		pos_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				pos_ch.ready <= 1'b0;
			end else begin
				pos_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (pos_ch.valid && pos_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	task automatic send_seq(input logic [BYTE_W-1:0] seq[$]);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic drain();
		byte_ch.valid <= 1'b0;
		@(negedge clk);
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.mouse_mode <= m;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int unsigned n;
		logic [BYTE_W-1:0] b;
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.mouse_mode <= MODE_STD;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_seq('{8'h07, 8'hFF, 8'h00, 8'h30, 8'h00, 8'h01});
		write_mode(MODE_WHEEL);
		send_seq('{8'h08, 8'h7F, 8'h80, 8'h80, 8'h0F, 8'h01, 8'hFF, 8'h7F});
		write_mode(MODE_FIVE);
		send_seq('{8'h0F, 8'h00, 8'h00, 8'h38, 8'h08, 8'hFF, 8'hFF, 8'h07});
		send_seq('{8'h3F, 8'h80});
		write_mode(MODE_SPARE);
		send_seq('{8'h3F, 8'h80, 8'h80});

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 48;
				end
				1: begin
					send_idle_pct = 48;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int s = 0; s < 3; s++) begin
				write_mode(MODE_W'((ph * 3 + s) % 4));
				if (ph == 2 && s == 0)
					hold_req = HOLD_CYCLES;
				n = $urandom_range(70, 90);
				repeat (n) begin
					case ($urandom_range(7))
						0: b = 8'h00;
						1: b = 8'hFF;
						2: b = 8'h80;
						3: b = 8'h7F;
						default: b = BYTE_W'($urandom);
					endcase
					send_byte(b);
				end
			end
		end

		byte_ch.valid <= 1'b0;
		@(negedge clk);
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== pointer_packet_decoder.f =====
src/ppd_pkg.sv
src/ppd_if.sv
src/ppd_asm.sv
src/ppd_acc.sv
src/pointer_packet_decoder.sv
tb/testbench.sv
